>>> hw/rtl/growing_window_moving_average_macros.svh
// Assertion macros for the moving average block.
`ifndef GROWING_WINDOW_MOVING_AVERAGE_MACROS_SVH
`define GROWING_WINDOW_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GWMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gwma: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GWMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gwma: next-cycle check failed");

`endif

>>> hw/rtl/gwma_pkg.sv
// Shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package gwma_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned DEFAULT_WINDOW = 8;

  typedef struct packed {
    logic accept;    // latch sample, read oldest ring entry
    logic upd;       // update ring, sum, position and fill count
    logic div_load;  // start the divider
    logic div_step;  // one quotient bit
    logic out_load;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // current step produces the last quotient bit
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/gwma_dp.sv
// Datapath: sample ring, running sum, fill count and bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none
module gwma_dp import gwma_pkg::*; #(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [DATA_W-1:0] sample_i,
  output logic      [DATA_W-1:0] average_o
);

  localparam int unsigned SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic        [DATA_W-1:0] ring_mem [WINDOW];
  logic        [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] sample_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic        [PTR_W-1:0]  pos_q, pos_d;
  logic        [CNT_W-1:0]  fill_q, fill_d;
  logic        [SUM_W-1:0]  quo_q, quo_d;
  logic        [CNT_W-1:0]  rem_q, rem_d;
  logic        [STEP_W-1:0] step_q, step_d;
  logic                     neg_q, neg_d;
  logic        [DATA_W-1:0] avg_q;

  logic                     full;
  logic signed [DATA_W-1:0] old_val;
  logic signed [SUM_W:0]    sum_ext;
  logic        [CNT_W:0]    shifted;
  logic        [CNT_W+1:0]  trial;

  assign full    = (fill_q == CNT_W'(WINDOW));
  assign old_val = full ? $signed(rd_q) : '0;
  assign sum_ext = (SUM_W+1)'(sum_q) - (SUM_W+1)'(old_val) + (SUM_W+1)'(sample_q);
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, fill_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      ring_mem[pos_q] <= sample_q;
    end
    if (cmd_i.accept) begin
      rd_q     <= ring_mem[pos_q];
      sample_q <= $signed(sample_i);
    end
    if (cmd_i.out_load) begin
      avg_q <= neg_q ? (DATA_W'(0) - quo_q[DATA_W-1:0]) : quo_q[DATA_W-1:0];
    end
  end

  always_comb begin
    sum_d  = sum_q;
    pos_d  = pos_q;
    fill_d = fill_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    neg_d  = neg_q;
    if (cmd_i.upd) begin
      sum_d = sum_ext[SUM_W-1:0];
      pos_d = (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + PTR_W'(1);
      if (!full) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
    if (cmd_i.div_load) begin
      neg_d  = sum_q[SUM_W-1];
      quo_d  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
      rem_d  = '0;
      step_d = STEP_W'(SUM_W - 1);
    end
    if (cmd_i.div_step) begin
      if (!trial[CNT_W+1]) begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pos_q  <= '0;
      fill_q <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      step_q <= '0;
      neg_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      pos_q  <= pos_d;
      fill_q <= fill_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      step_q <= step_d;
      neg_q  <= neg_d;
    end
  end

  assign sts_o.div_last = (step_q == '0);
  assign average_o      = avg_q;

endmodule
`default_nettype wire

>>> hw/rtl/gwma_ctrl.sv
// Controller: sequences one word through update, divide and output.
`timescale 1ns / 1ps
`default_nettype none
module gwma_ctrl import gwma_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/growing_window_moving_average.sv
// Growing-window moving average, top level.
// Each input word is a signed 16-bit sample; each output word is the mean of
// the last WINDOW samples (fewer while the window is still filling), truncated
// toward zero. One word is processed at a time: the sum is updated, then divided
// by a one-bit-per-cycle divider, and the next word is accepted only after the
// result is loaded into the output register.
// The finished result sits in an output register, so the next sample is taken
// while it waits. The sample ring needs no clearing pass after reset: the fill
// count masks entries not yet written.
`timescale 1ns / 1ps
`default_nettype none
`include "growing_window_moving_average_macros.svh"
module growing_window_moving_average import gwma_pkg::*; #(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,  // [15:0] sample
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [DATA_W-1:0] m_axis_tdata   // [15:0] average
);

  cmd_t cmd;
  sts_t sts;

  gwma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gwma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .sample_i  (s_axis_tdata),
    .average_o (m_axis_tdata)
  );

  `GWMA_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
  `GWMA_ASSERT_NEXT(a_accept_then_update, s_axis_tvalid && s_axis_tready, cmd.upd && !s_axis_tready)
  `GWMA_ASSERT_NEXT(a_div_stops, cmd.div_step && sts.div_last, !cmd.div_step)
  `GWMA_ASSERT_NEXT(a_load_shows, cmd.out_load, m_axis_tvalid)

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the growing-window moving average block.
`timescale 1ns / 1ps
module tb;
  import gwma_pkg::*;

  localparam int unsigned WIN = DEFAULT_WINDOW;
  localparam int unsigned N_RANDOM = 1600;

  // Tracks ring, sum and fill count; holds averages not yet seen at the output.
  class avg_scoreboard;
    logic signed [DATA_W-1:0] ring[WIN];
    logic signed [DATA_W+$clog2(WIN+1):0] sum;
    int unsigned wr_pos;
    int unsigned fill;
    logic [DATA_W-1:0] avg_q[$];
    int unsigned failures;

    function new();
      foreach (ring[i]) ring[i] = '0;
      sum = '0;
      wr_pos = 0;
      fill = 0;
      failures = 0;
    endfunction

    function void note_sample(input logic [DATA_W-1:0] word);
      logic signed [DATA_W-1:0] s;
      int num;
      int den;
      int q;
      s = word;
      sum = sum - ring[wr_pos] + s;
      ring[wr_pos] = s;
      wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
      if (fill < WIN) fill++;
      num = sum;
      den = fill;
      q = num / den;
      avg_q.push_back(q[DATA_W-1:0]);
    endfunction

    function void check_average(input logic [DATA_W-1:0] word);
      logic [DATA_W-1:0] want;
      if (avg_q.size() == 0) begin
        if (failures < 10) $display("unexpected average word %h", word);
        failures++;
        return;
      end
      want = avg_q.pop_front();
      if (word !== want) begin
        if (failures < 10) $display("average mismatch: expected %h, got %h", want, word);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return avg_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  avg_scoreboard sb = new();
  bit rx_hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  growing_window_moving_average #(.WINDOW(WIN)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  task automatic send_sample(input logic [DATA_W-1:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(word);
  endtask

  task automatic drain_averages();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 15)) - 16'd8;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Receiver: stall runs whose density depends on a slowly changing mode.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_left = 0;
    stall_left = 0;
    mode = 0;
    mode_left = 200;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_average(m_axis_tdata);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        case (mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 5);
          2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 30);
          3: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(10, 60);
          default: ;
        endcase
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] directed[$];
    int unsigned n;
    int unsigned burst;
    int unsigned gap;
    bit hold_done;
    bit drain_done;
    directed = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFD, 16'h0005,
                 16'hFFF9, 16'hFFFF};
    repeat (8) directed.push_back(16'h7FFF);
    repeat (8) directed.push_back(16'h8000);
    hold_done = 1'b0;
    drain_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_sample(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_averages();

    n = 0;
    while (n < N_RANDOM) begin
      if (!hold_done && n >= 500) begin
        // long output hold-off while input keeps coming back to back
        hold_done = 1'b1;
        rx_hold_req = 1'b1;
        repeat (12) send_sample(pick_sample());
        n += 12;
      end else if (!drain_done && n >= 1000) begin
        drain_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        drain_averages();
        @(posedge clk_i);
        n += 20;
      end
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_sample(pick_sample());
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    drain_averages();
    repeat (60) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/gwma_pkg.sv
hw/rtl/gwma_dp.sv
hw/rtl/gwma_ctrl.sv
hw/rtl/growing_window_moving_average.sv
tb/sv/tb.sv
